### rtl/core/round_robin_ticket_queue_unit_macros.svh
// Assertion macros for the round-robin ticket queue unit.
// Self-contained; taken in by the top level through an include.
`ifndef ROUND_ROBIN_TICKET_QUEUE_UNIT_MACROS_SVH
`define ROUND_ROBIN_TICKET_QUEUE_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define RRTQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define RRTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rrtq_pkg.sv
// Shared types and constants for the round-robin ticket queue unit.
// No dependencies; compile first.
package rrtq_pkg;

    localparam int ID_W            = 16;
    localparam int TK_W            = 8;
    localparam int ST_W            = 3;
    localparam int QUEUE_DEPTH_DEF = 64;

    typedef enum logic [ST_W-1:0] {
        ST_ENTERED  = 3'd0,
        ST_FULL     = 3'd1,
        ST_REQUEUED = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic {
        CMD_ENTER = 1'b0,
        CMD_SERVE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [TK_W-1:0] tickets;
    } entry_t;

    typedef struct packed {
        cmd_t            cmd;
        logic [ID_W-1:0] customer_id;
        logic [TK_W-1:0] ticket_count;
    } item_t;

    typedef struct packed {
        status_t         status;
        logic [ID_W-1:0] served_id;
        logic [TK_W-1:0] served_left;
        logic            head_valid;
        logic [ID_W-1:0] head_id;
        logic [TK_W-1:0] head_tickets;
    } result_t;

endpackage

### rtl/core/rrtq_in_if.sv
// Request channel interface: valid/ready plus one queue command.
// Depends on rrtq_pkg.
interface rrtq_in_if;
    import rrtq_pkg::*;

    logic            valid;
    logic            ready;
    logic            cmd;
    logic [ID_W-1:0] customer_id;
    logic [TK_W-1:0] ticket_count;

    modport source (output valid, output cmd, output customer_id, output ticket_count,
                    input ready);
    modport sink   (input valid, input cmd, input customer_id, input ticket_count,
                    output ready);
endinterface

### rtl/core/rrtq_out_if.sv
// Result channel interface: valid/ready plus one queue result.
// Depends on rrtq_pkg; occupancy width follows the queue depth.
interface rrtq_out_if #(
    parameter int OCC_W = $clog2(rrtq_pkg::QUEUE_DEPTH_DEF + 1)
);
    import rrtq_pkg::*;

    logic             valid;
    logic             ready;
    status_t          status;
    logic [ID_W-1:0]  served_id;
    logic [TK_W-1:0]  served_left;
    logic             head_valid;
    logic [ID_W-1:0]  head_id;
    logic [TK_W-1:0]  head_tickets;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output status, output served_id, output served_left,
                    output head_valid, output head_id, output head_tickets,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input served_id, input served_left,
                    input head_valid, input head_id, input head_tickets,
                    input occupancy, output ready);
endinterface

### rtl/core/rrtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the contents before a same-edge write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

### rtl/core/rrtq_ctrl.sv
// Queue state, head prefetch and single-pass command step.
// Depends on rrtq_pkg and rrtq_ram.
module rrtq_ctrl #(
    parameter int QUEUE_DEPTH = rrtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              take,
    input  rrtq_pkg::item_t                   item,
    output rrtq_pkg::result_t                 res,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  occ_next,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  occ
);
    import rrtq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [CW-1:0] count_reg, count_next;
    entry_t        head_reg, head_next;
    logic          byp_valid_reg, byp_valid_next;
    entry_t        byp_data_reg;

    logic          wr_en;
    entry_t        wr_data;
    logic [PW-1:0] rd_addr;
    entry_t        rd_data;
    entry_t        second;
    logic [TK_W-1:0] left;

    rrtq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // entry behind the head; take the bypass when it was written at the read edge
    assign second = byp_valid_reg ? byp_data_reg : rd_data;
    assign left   = head_reg.tickets - TK_W'(1);

    always_comb
    begin
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        wr_en           = 1'b0;
        wr_data.id      = item.customer_id;
        wr_data.tickets = item.ticket_count;
        res.status      = ST_EMPTY;
        res.served_id   = '0;
        res.served_left = '0;
        if (take)
        begin
            if (item.cmd == CMD_ENTER)
            begin
                if (count_reg == CW'(QUEUE_DEPTH))
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wp_next    = ptr_inc(wp_reg);
                    count_next = count_reg + CW'(1);
                    res.status = ST_ENTERED;
                    if (count_reg == '0)
                    begin
                        head_next = wr_data;
                    end
                end
            end
            else if (count_reg != '0)
            begin
                res.served_id = head_reg.id;
                rp_next       = ptr_inc(rp_reg);
                if (head_reg.tickets <= TK_W'(1))
                begin
                    res.status = ST_REMOVED;
                    count_next = count_reg - CW'(1);
                    head_next  = second;
                end
                else
                begin
                    // requeue at the tail; the freed head slot keeps room for it
                    wr_en           = 1'b1;
                    wr_data.id      = head_reg.id;
                    wr_data.tickets = left;
                    wp_next         = ptr_inc(wp_reg);
                    res.status      = ST_REQUEUED;
                    res.served_left = left;
                    head_next       = (count_reg == CW'(1)) ? wr_data : second;
                end
            end
        end
        res.head_valid   = (count_next != '0);
        res.head_id      = res.head_valid ? head_next.id : '0;
        res.head_tickets = res.head_valid ? head_next.tickets : '0;
    end

    assign rd_addr        = ptr_inc(rp_next);
    assign byp_valid_next = wr_en && (wp_reg == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg     <= head_next;
        byp_data_reg <= wr_data;
    end

    assign occ_next = count_next;
    assign occ      = count_reg;
endmodule

### rtl/core/round_robin_ticket_queue_unit.sv
// Top level of the round-robin ticket queue unit: handshake and result register.
// Depends on rrtq_pkg, rrtq_in_if, rrtq_out_if, rrtq_ctrl and the macros header.
//
//  channel | dir | modport | payload
//  --------+-----+---------+------------------------------------------------------
//  req     | in  | sink    | cmd, customer_id, ticket_count
//  rsp     | out | source  | status, served_id, served_left, head_valid, head_id,
//          |     |         | head_tickets, occupancy
//
// One transfer in per cycle and one result per transfer, shown the cycle after.
// The step runs in a single pass against the head register and a RAM read of
// the entry behind the head, issued ahead of its use, with a write bypass.
// Reset empties the queue at once; the entry store needs no clearing.
// While a result waits untaken, req.ready drops; it holds high otherwise.
`include "round_robin_ticket_queue_unit_macros.svh"

module round_robin_ticket_queue_unit #(
    parameter int QUEUE_DEPTH = rrtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rrtq_in_if.sink    req,
    rrtq_out_if.source rsp
);
    import rrtq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          take;
    item_t         item;
    result_t       res;
    logic [CW-1:0] occ_next;
    logic [CW-1:0] occ;

    logic          rsp_valid_reg, rsp_valid_next;
    result_t       res_reg;
    logic [CW-1:0] occ_reg;

    // accept when the result register is empty or being drained this cycle
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;

    assign item.cmd          = cmd_t'(req.cmd);
    assign item.customer_id  = req.customer_id;
    assign item.ticket_count = req.ticket_count;

    rrtq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (item),
        .res      (res),
        .occ_next (occ_next),
        .occ      (occ)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // load the result with each transfer in; hold it otherwise
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res;
            occ_reg <= occ_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = res_reg.status;
    assign rsp.served_id    = res_reg.served_id;
    assign rsp.served_left  = res_reg.served_left;
    assign rsp.head_valid   = res_reg.head_valid;
    assign rsp.head_id      = res_reg.head_id;
    assign rsp.head_tickets = res_reg.head_tickets;
    assign rsp.occupancy    = occ_reg;

    // head flag must agree with the reported occupancy
    `RRTQ_ASSERT_NOW(a_head_vs_occ, clk, rst_n, rsp_valid_reg,
        res_reg.head_valid == (occ_reg != '0),
        "head_valid disagrees with occupancy")
    // a serve on an empty queue reports empty
    `RRTQ_ASSERT_NEXT(a_serve_empty, clk, rst_n,
        take && item.cmd == CMD_SERVE && occ == '0,
        rsp_valid_reg && res_reg.status == ST_EMPTY,
        "serve on empty queue not reported empty")
    // an enter on a full queue is rejected and leaves the count alone
    `RRTQ_ASSERT_NEXT(a_enter_full, clk, rst_n,
        take && item.cmd == CMD_ENTER && occ == CW'(QUEUE_DEPTH),
        res_reg.status == ST_FULL && occ == CW'(QUEUE_DEPTH),
        "enter on full queue not rejected")
    // a requeued requester always has tickets left
    `RRTQ_ASSERT_NOW(a_requeue_left, clk, rst_n,
        rsp_valid_reg && res_reg.status == ST_REQUEUED,
        res_reg.served_left != '0 && res_reg.head_valid,
        "requeue with no tickets left")
endmodule
